[hdl/sact_pkg.sv]
// ----------------------------------------------------------------------------
// sact_pkg
// Shared constants and types of the set-associative tag controller.
// ----------------------------------------------------------------------------
package sact_pkg;

	localparam int unsigned MAX_SETS_DEF  = 256;
	localparam int unsigned MAX_WAYS_DEF  = 8;
	localparam int unsigned FREQ_BITS_DEF = 16;

	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 4;
	localparam int unsigned OFFS_MAX  = 12;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_POLICY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WMODE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ASSOC  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd4;

	// Classified access handed from the front to the back.
	typedef struct packed {
		logic                    is_write;
		logic [ADDR_W-1:0]       tag;
		logic [11:0]             set;
	} acc_t;

	// Result beat.
	typedef struct packed {
		logic       hit;
		logic [2:0] hit_way;
		logic       allocated;
		logic       dirty_eviction;
		logic [1:0] memory_transfers;
	} res_t;

endpackage

[hdl/sact_if.sv]
// ----------------------------------------------------------------------------
// sact_access_if / sact_result_if / sact_cfg_if
// Valid/ready channels of the tag controller.
// ----------------------------------------------------------------------------
interface sact_access_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] address;
	modport source (output valid, operation, address, input ready);
	modport sink   (input valid, operation, address, output ready);
endinterface

interface sact_result_if;
	logic       valid;
	logic       ready;
	logic       hit;
	logic [2:0] hit_way;
	logic       allocated;
	logic       dirty_eviction;
	logic [1:0] memory_transfers;
	modport source (output valid, hit, hit_way, allocated, dirty_eviction,
		memory_transfers, input ready);
	modport sink   (input valid, hit, hit_way, allocated, dirty_eviction,
		memory_transfers, output ready);
endinterface

interface sact_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [3:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[hdl/sact_front.sv]
// ----------------------------------------------------------------------------
// sact_front
// Splits each address into tag and set, and pushes it into a two-entry queue.
// ----------------------------------------------------------------------------
module sact_front #(
	parameter int unsigned MAX_SETS = sact_pkg::MAX_SETS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_op,
	input  logic [31:0]        in_addr,
	input  logic [3:0]         index_bits,
	input  logic [3:0]         offset_bits,
	output logic               q_valid,
	input  logic               q_pop,
	output sact_pkg::acc_t     q_head
);
	import sact_pkg::*;

	// Widest index whose set count still fits in MAX_SETS.
	localparam int unsigned MAXIB = $clog2(MAX_SETS + 1) - 1;

	acc_t       fifo_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	acc_t       cls;
	logic [3:0] ob, ib;
	logic [31:0] sh, idx_mask;
	logic        push;

	// Classification of the incoming beat.
	always_comb begin
		ob = (offset_bits > 4'(OFFS_MAX)) ? 4'(OFFS_MAX) : offset_bits;
		ib = (index_bits > 4'(MAXIB)) ? 4'(MAXIB) : index_bits;
		sh = in_addr >> ob;
		idx_mask = ~(32'hFFFF_FFFF << ib);
		cls.is_write = in_op;
		cls.set = 12'(sh & idx_mask);
		cls.tag = sh >> ib;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_head   = fifo_q[rd_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= cls;
		end
	end

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

[hdl/sact_back.sv]
// ----------------------------------------------------------------------------
// sact_back
// Reads a set, decides hit and victim, and writes the set back.
// ----------------------------------------------------------------------------
module sact_back #(
	parameter int unsigned MAX_SETS  = sact_pkg::MAX_SETS_DEF,
	parameter int unsigned MAX_WAYS  = sact_pkg::MAX_WAYS_DEF,
	parameter int unsigned FREQ_BITS = sact_pkg::FREQ_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  sact_pkg::acc_t     q_head,
	input  logic               policy,
	input  logic               wmode,
	input  logic [3:0]         assoc,
	output logic               res_valid,
	input  logic               res_ready,
	output sact_pkg::res_t     res
);
	import sact_pkg::*;

	localparam int unsigned SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int unsigned WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int unsigned AW = WW;
	localparam logic [AW-1:0] AGE_MAX = AW'(MAX_WAYS - 1);
	localparam logic [FREQ_BITS-1:0] FMAX = '1;

	typedef struct packed {
		logic                 valid;
		logic [ADDR_W-1:0]    tag;
		logic                 dirty;
		logic [AW-1:0]        age;
		logic [FREQ_BITS-1:0] freq;
	} line_t;

	typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_OUT} state_t;

	line_t            mem_q [MAX_SETS][MAX_WAYS];
	line_t            rd_s1 [MAX_WAYS];
	line_t            nl    [MAX_WAYS];
	logic [MAX_WAYS-1:0] vrow;
	logic [MAX_SETS-1:0] touched_q;
	state_t           state_q;
	acc_t             acc_s1;
	res_t             res_q, nres;
	logic [SW-1:0]    set_ix;
	logic             wr_en;

	logic [4:0]       ways;
	logic             hit;
	logic [WW-1:0]    hw, vict, way;
	logic             alloc, dev;
	logic [1:0]       xf;

	assign set_ix = SW'(q_head.set);
	assign q_pop  = (state_q == ST_IDLE) && q_valid;
	assign res_valid = (state_q == ST_OUT);
	assign res = res_q;

	// Set read; untouched sets read as their reset contents.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			acc_s1 <= q_head;
			for (int w = 0; w < MAX_WAYS; w++) begin
				if (touched_q[set_ix]) begin
					rd_s1[w] <= mem_q[set_ix][w];
				end else begin
					rd_s1[w].valid <= 1'b0;
					rd_s1[w].tag   <= '0;
					rd_s1[w].dirty <= 1'b0;
					rd_s1[w].age   <= AW'(MAX_WAYS - 1 - w);
					rd_s1[w].freq  <= '0;
				end
			end
		end
		if (wr_en) begin
			for (int w = 0; w < MAX_WAYS; w++) begin
				mem_q[SW'(acc_s1.set)][w] <= nl[w];
			end
		end
	end

	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) vrow[w] = rd_s1[w].valid;
	end

	// Hit search, victim choice and counter update.
	always_comb begin
		ways = (assoc == 4'd0) ? 5'd1 :
			((5'(assoc) > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : 5'(assoc));
		hit = 1'b0;
		hw = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (5'(w) < ways && vrow[w] && rd_s1[w].tag == acc_s1.tag) begin
				hit = 1'b1;
				hw = WW'(w);
			end
		end
		vict = '0;
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (5'(w) < ways) begin
				if (policy ? (rd_s1[w].freq < rd_s1[vict].freq)
					: (rd_s1[w].age > rd_s1[vict].age)) begin
					vict = WW'(w);
				end
			end
		end
		for (int w = 0; w < MAX_WAYS; w++) nl[w] = rd_s1[w];
		alloc = 1'b0;
		dev = 1'b0;
		xf = 2'd0;
		way = '0;
		if (hit) begin
			way = hw;
			if (policy) begin
				if (rd_s1[hw].freq != FMAX) nl[hw].freq = rd_s1[hw].freq + 1'b1;
			end else begin
				for (int w = 0; w < MAX_WAYS; w++) begin
					if (5'(w) < ways && rd_s1[w].age < rd_s1[hw].age
						&& rd_s1[w].age != AGE_MAX) begin
						nl[w].age = rd_s1[w].age + 1'b1;
					end
				end
				nl[hw].age = '0;
			end
			if (acc_s1.is_write) begin
				if (wmode) xf = 2'd1;
				else nl[hw].dirty = 1'b1;
			end
		end else begin
			xf = 2'd1;
			if (!wmode || !acc_s1.is_write) begin
				way = vict;
				alloc = 1'b1;
				if (policy) begin
					if (rd_s1[vict].freq != FMAX) nl[vict].freq = rd_s1[vict].freq + 1'b1;
				end else begin
					for (int w = 0; w < MAX_WAYS; w++) begin
						if (5'(w) < ways && WW'(w) != vict && rd_s1[w].age != AGE_MAX) begin
							nl[w].age = rd_s1[w].age + 1'b1;
						end
					end
					nl[vict].age = '0;
				end
				if (vrow[vict] && rd_s1[vict].dirty) begin
					dev = 1'b1;
					xf = 2'd2;
				end
				nl[vict].tag = acc_s1.tag;
				nl[vict].dirty = !wmode && acc_s1.is_write;
				nl[vict].valid = 1'b1;
			end
		end
		nres.hit = hit;
		nres.hit_way = 3'(way);
		nres.allocated = alloc;
		nres.dirty_eviction = dev;
		nres.memory_transfers = xf;
	end

	assign wr_en = (state_q == ST_EVAL);

	always_ff @(posedge clk) begin
		if (wr_en) res_q <= nres;
	end

	// Sequencer and written-set marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			touched_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (q_valid) state_q <= ST_EVAL;
				ST_EVAL: begin
					state_q <= ST_OUT;
					touched_q[SW'(acc_s1.set)] <= 1'b1;
				end
				ST_OUT: if (res_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hdl/set_assoc_cache_tag_controller_core.sv]
// An accepted access enters a two-entry queue, then goes through set read,
// evaluate and write back, and result hand-off; the next access is popped only
// after the result is handed off, and the queue decouples the access port.
// Reset: all lines invalid, LRU ages and LFU counts at their reset values.
// Configuration resets to LRU, write-back, 8 ways, 8 index and 5 offset bits.
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller_core
// Top level of the set-associative cache tag and replacement controller.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_controller_core #(
	parameter int unsigned MAX_SETS  = sact_pkg::MAX_SETS_DEF,
	parameter int unsigned MAX_WAYS  = sact_pkg::MAX_WAYS_DEF,
	parameter int unsigned FREQ_BITS = sact_pkg::FREQ_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	sact_access_if.sink   access,
	sact_result_if.source result,
	sact_cfg_if.sink      cfg
);
	import sact_pkg::*;

	logic       policy_q, wmode_q;
	logic [3:0] assoc_q, ib_q, ob_q;
	logic       q_valid, q_pop;
	acc_t       q_head;
	res_t       res;

	assign cfg.ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= 1'b0;
			wmode_q  <= 1'b0;
			assoc_q  <= 4'd8;
			ib_q     <= 4'd8;
			ob_q     <= 4'd5;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_POLICY: policy_q <= cfg.data[0];
				REG_WMODE:  wmode_q  <= cfg.data[0];
				REG_ASSOC:  assoc_q  <= cfg.data;
				REG_INDEX:  ib_q     <= cfg.data;
				REG_OFFSET: ob_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	sact_front #(.MAX_SETS(MAX_SETS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(access.valid), .in_ready(access.ready),
		.in_op(access.operation), .in_addr(access.address),
		.index_bits(ib_q), .offset_bits(ob_q),
		.q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
	);

	sact_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .FREQ_BITS(FREQ_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
		.policy(policy_q), .wmode(wmode_q), .assoc(assoc_q),
		.res_valid(result.valid), .res_ready(result.ready), .res(res)
	);

	assign result.hit              = res.hit;
	assign result.hit_way          = res.hit_way;
	assign result.allocated        = res.allocated;
	assign result.dirty_eviction   = res.dirty_eviction;
	assign result.memory_transfers = res.memory_transfers;

endmodule
